[rtl/swing_step_clock_unit_macros.svh]
// Assertion helpers used by the RTL controller.
`ifndef SWING_STEP_CLOCK_UNIT_MACROS_SVH
`define SWING_STEP_CLOCK_UNIT_MACROS_SVH

// Concurrent check, sampled on the rising clock and held off during reset.
`define SWSC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent check that also runs while reset is asserted.
`define SWSC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/swsc_pkg.sv]
package swsc_pkg;

    // Default number of fraction bits in the bar position.
    localparam int FRACTION_BITS_DEF = 28;

    // Field and register widths.
    localparam int CMD_W     = 2;
    localparam int SAMPLES_W = 16;
    localparam int BPM_W     = 15;
    localparam int SWING_W   = 8;
    localparam int SR_W      = 18;
    localparam int STEP_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 18;

    // Numerator is samples times tempo; denominator is 6000 times the sample rate.
    localparam int NUM_W     = SAMPLES_W + BPM_W;
    localparam int DEN_SCALE = 6000;
    localparam int DEN_W     = 31;

    // Register limits and reset values.
    localparam logic [BPM_W-1:0]   BPM_MIN     = 15'd4000;
    localparam logic [BPM_W-1:0]   BPM_MAX     = 15'd24000;
    localparam logic [BPM_W-1:0]   BPM_RESET   = 15'd12000;
    localparam logic [SWING_W-1:0] SWING_MAX   = 8'd192;
    localparam logic [SWING_W-1:0] SWING_RESET = 8'd0;
    localparam logic [SR_W-1:0]    SR_RESET    = 18'd48000;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP    = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BPM   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SWING = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SR    = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch the request fields
        logic mul;       // form numerator and denominator, clear the divider
        logic div_step;  // one restoring division step
        logic commit;    // update the transport state and load the result
    } swsc_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic adv_go;    // the captured request moves the position
    } swsc_sts_t;

endpackage

[rtl/swsc_if.sv]
// Request channel: command and sample count.
interface swsc_req_if;
    logic                           valid;
    logic                           ready;
    logic [swsc_pkg::CMD_W-1:0]     cmd;
    logic [swsc_pkg::SAMPLES_W-1:0] num_samples;

    modport source (output valid, output cmd, output num_samples, input ready);
    modport sink (input valid, input cmd, input num_samples, output ready);
endinterface

// Result channel: step and run flag after each request.
interface swsc_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [swsc_pkg::STEP_W-1:0] current_step;
    logic                        is_running;

    modport source (output valid, output current_step, output is_running, input ready);
    modport sink (input valid, input current_step, input is_running, output ready);
endinterface

[rtl/swsc_datapath.sv]
module swsc_datapath #(
    parameter int FRACTION_BITS = swsc_pkg::FRACTION_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  swsc_pkg::swsc_ctl_t            ctl,
    output swsc_pkg::swsc_sts_t            sts,
    input  logic [swsc_pkg::CMD_W-1:0]     req_cmd,
    input  logic [swsc_pkg::SAMPLES_W-1:0] req_num_samples,
    input  logic                           cfg_we,
    input  logic [swsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [swsc_pkg::CFG_W-1:0]     cfg_data,
    output logic [swsc_pkg::STEP_W-1:0]    current_step,
    output logic                           is_running
);
    import swsc_pkg::*;

    localparam int POS_W   = FRACTION_BITS + 2;
    localparam int PHASE_W = FRACTION_BITS - 1;
    localparam int SHIFT_W = FRACTION_BITS - 10;

    // Configuration registers.
    logic [BPM_W-1:0]   bpm_reg;
    logic [SWING_W-1:0] swing_reg;
    logic [SR_W-1:0]    sr_reg;

    // Captured request.
    logic [CMD_W-1:0]     cmd_reg;
    logic [SAMPLES_W-1:0] samples_reg;

    // Divider.
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [POS_W-1:0] quo_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             qbit;

    // Transport state and result.
    logic              run_reg;
    logic              run_next;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [POS_W-1:0]  pos_sum;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [STEP_W-1:0] step_adv;
    logic [PHASE_W-1:0] first_len;
    logic [STEP_W-1:0] out_step_reg;
    logic              out_run_reg;

    // Configuration writes, tempo and swing saturating; an unused index is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpm_reg   <= BPM_RESET;
            swing_reg <= SWING_RESET;
            sr_reg    <= SR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BPM:
                begin
                    if (cfg_data[BPM_W-1:0] < BPM_MIN)
                        bpm_reg <= BPM_MIN;
                    else if (cfg_data[BPM_W-1:0] > BPM_MAX)
                        bpm_reg <= BPM_MAX;
                    else
                        bpm_reg <= cfg_data[BPM_W-1:0];
                end
                REG_SWING:
                begin
                    if (cfg_data[SWING_W-1:0] > SWING_MAX)
                        swing_reg <= SWING_MAX;
                    else
                        swing_reg <= cfg_data[SWING_W-1:0];
                end
                REG_SR:
                    sr_reg <= cfg_data[SR_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg     <= req_cmd;
            samples_reg <= req_num_samples;
        end
    end

    // The position moves only on an advance while running with a usable rate.
    assign sts.adv_go = (cmd_reg == CMD_ADVANCE) && run_reg &&
                        (samples_reg != '0) && (sr_reg != '0);

    // One restoring step: bring down the next dividend bit, subtract if it fits.
    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign qbit  = !diff[DEN_W];

    always_ff @(posedge clk)
    begin
        if (ctl.mul)
        begin
            num_reg <= NUM_W'(samples_reg) * NUM_W'(bpm_reg);
            den_reg <= DEN_W'(sr_reg) * DEN_W'(DEN_SCALE);
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (ctl.div_step)
        begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[POS_W-2:0], qbit};
        end
    end

    // New position and its swung step; the first step of a pair is stretched.
    assign pos_sum   = pos_reg + quo_reg;
    assign first_len = {9'(9'd256 + 9'(swing_reg)), SHIFT_W'(0)};
    assign step_adv  = {pos_sum[POS_W-1:PHASE_W], (pos_sum[PHASE_W-1:0] >= first_len)};

    always_comb
    begin
        run_next  = run_reg;
        pos_next  = pos_reg;
        step_next = step_reg;
        case (cmd_reg)
            CMD_ADVANCE:
            begin
                if (sts.adv_go)
                begin
                    pos_next  = pos_sum;
                    step_next = step_adv;
                end
            end
            CMD_START:
                run_next = 1'b1;
            CMD_STOP:
            begin
                run_next  = 1'b0;
                pos_next  = '0;
                step_next = '0;
            end
            default:
                ;
        endcase
    end

    // Transport state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            pos_reg  <= '0;
            step_reg <= '0;
        end
        else if (ctl.commit)
        begin
            run_reg  <= run_next;
            pos_reg  <= pos_next;
            step_reg <= step_next;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            out_step_reg <= step_next;
            out_run_reg  <= run_next;
        end
    end

    assign current_step = out_step_reg;
    assign is_running   = out_run_reg;

endmodule

[rtl/swsc_controller.sv]
`include "swing_step_clock_unit_macros.svh"

module swsc_controller #(
    parameter int FRACTION_BITS = swsc_pkg::FRACTION_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    input  swsc_pkg::swsc_sts_t sts,
    output swsc_pkg::swsc_ctl_t ctl
);
    import swsc_pkg::*;

    localparam int DIV_STEPS = NUM_W + FRACTION_BITS;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MUL   = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;
    localparam logic [1:0] S_WRITE = 2'd3;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    logic             slot_free;
    logic             last_step;

    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign last_step = (cnt_reg == CNT_W'(DIV_STEPS - 1));

    // Sequencer: capture, multiply, divide one bit a cycle for a moving advance, then commit.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        ctl            = '0;
        req_ready      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready   = 1'b1;
                ctl.capture = req_valid;
                if (req_valid)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                ctl.mul  = 1'b1;
                cnt_next = '0;
                state_next = sts.adv_go ? S_DIV : S_WRITE;
            end
            S_DIV:
            begin
                ctl.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (last_step)
                    state_next = S_WRITE;
            end
            S_WRITE:
            begin
                if (slot_free)
                begin
                    ctl.commit     = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

    // The divider count never runs past the last quotient bit.
    `SWSC_ASSERT(a_cnt_bound, clk, rst_n, (state_reg == S_DIV) |-> (cnt_reg < CNT_W'(DIV_STEPS)), "divider count overran")
    // A result is loaded only into a free output slot.
    `SWSC_ASSERT(a_commit_free, clk, rst_n, ctl.commit |-> slot_free, "result overwrote a pending one")
    // An accepted request always goes to the multiply step next.
    `SWSC_ASSERT(a_accept_mul, clk, rst_n, (req_valid && req_ready) |=> (state_reg == S_MUL), "request not sequenced")

endmodule

[rtl/swing_step_clock_unit.sv]
// Transport clock with swing for a step sequencer.
// Requests arrive on req (valid/ready): cmd 0 advances the bar position by
// num_samples worth of time while running, cmd 1 starts the transport, cmd 2 stops it and
// clears position and step. Every request gives exactly one result on rsp:
// the sixteenth-note step and the run flag after that request.
// Tempo, swing and sample rate are written through cfg_we/cfg_index/cfg_data;
// tempo and swing saturate to their ranges. The user must write them only while
// no request is in flight; the block itself does not enforce this.
// A start, a stop or an advance that does not move the position goes from
// acceptance through the multiply step to the commit step; a moving advance also
// passes the one-bit-a-cycle restoring divider that forms the position increment.
// One request is processed at a time; req.ready is high while idle. A finished
// result sits in the output register, and the next request is taken while it
// waits. If rsp is stalled, the following result waits in the commit step
// until the output register is free.
// Reset clears the transport to stopped at position zero, step zero, and
// loads the default tempo, swing and sample rate; rsp.valid goes low.
module swing_step_clock_unit #(
    parameter int FRACTION_BITS = swsc_pkg::FRACTION_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    swsc_req_if.sink                       req,
    swsc_rsp_if.source                     rsp,
    input  logic                           cfg_we,
    input  logic [swsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [swsc_pkg::CFG_W-1:0]     cfg_data
);
    import swsc_pkg::*;

    swsc_ctl_t ctl;
    swsc_sts_t sts;

    // Sequencer.
    swsc_controller #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    // Registers, divider and transport state.
    swsc_datapath #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .sts             (sts),
        .req_cmd         (req.cmd),
        .req_num_samples (req.num_samples),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .current_step    (rsp.current_step),
        .is_running      (rsp.is_running)
    );

endmodule

[tb/swing_step_clock_unit_tb.sv]
`timescale 1ns / 1ps

module swing_step_clock_unit_tb;
    import swsc_pkg::*;

    localparam int FRAC  = FRACTION_BITS_DEF;
    localparam int POS_W = FRAC + 2;

    // Codes the package leaves unnamed.
    localparam logic [CMD_W-1:0]     CMD_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONE   = 2'd3;

    localparam int SETTLE_CYCLES = FRAC + 40;
    localparam int IDLE_LIMIT    = 2000;
    localparam int LONG_HOLD     = 300;

    typedef struct packed {
        logic [STEP_W-1:0] current_step;
        logic              is_running;
    } step_report_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    swsc_req_if req_if ();
    swsc_rsp_if rsp_if ();

    swing_step_clock_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Transport model, starting from the reset state.
    logic              clock_running = 1'b0;
    logic [POS_W-1:0]  bar_pos       = '0;
    logic [STEP_W-1:0] cur_step      = '0;
    logic [BPM_W-1:0]  tempo_centi   = BPM_RESET;
    logic [SWING_W-1:0] swing_units  = SWING_RESET;
    logic [SR_W-1:0]   rate_hz       = SR_RESET;

    step_report_t expected_steps[$];
    int           mismatches    = 0;
    int           idle_cycles   = 0;

    // Idling controls shared by the test tasks and the result sink.
    bit req_no_gaps   = 1'b0;
    bit rsp_no_stalls = 1'b0;
    int rsp_hold      = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Position increment for one block of samples, truncated, modulo one bar.
    function automatic logic [POS_W-1:0] bar_increment(logic [SAMPLES_W-1:0] samples);
        logic [127:0] scaled;
        logic [127:0] divisor;
        scaled  = (128'(samples) * 128'(tempo_centi)) << FRAC;
        divisor = 128'(DEN_SCALE) * 128'(rate_hz);
        return POS_W'(scaled / divisor);
    endfunction

    // Sixteenth-note step: the half-beat pair, then which side of the swung split.
    function automatic logic [STEP_W-1:0] step_of(logic [POS_W-1:0] pos);
        logic [2:0]  pair;
        logic [63:0] phase;
        logic [63:0] first_len;
        pair      = pos[POS_W-1 -: 3];
        phase     = 64'(pos[FRAC-2:0]);
        first_len = 64'(256 + swing_units) << (FRAC - 10);
        return {pair, phase >= first_len};
    endfunction

    // Apply one accepted request to the model and queue the result it yields.
    function automatic void advance_model(logic [CMD_W-1:0] cmd,
                                          logic [SAMPLES_W-1:0] samples);
        step_report_t res;
        case (cmd)
            CMD_ADVANCE:
            begin
                if (clock_running && samples != 0 && rate_hz != 0)
                begin
                    bar_pos  = bar_pos + bar_increment(samples);
                    cur_step = step_of(bar_pos);
                end
            end
            CMD_START:
            begin
                clock_running = 1'b1;
            end
            CMD_STOP:
            begin
                clock_running = 1'b0;
                bar_pos       = '0;
                cur_step      = '0;
            end
            default:
            begin
            end
        endcase
        res.current_step = cur_step;
        res.is_running   = clock_running;
        expected_steps.push_back(res);
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // Compare one accepted result with the oldest expected step.
    task automatic check_step();
        step_report_t want;
        if (expected_steps.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result step %0d running %0b",
                                      rsp_if.current_step, rsp_if.is_running));
            return;
        end
        want = expected_steps.pop_front();
        if (rsp_if.current_step !== want.current_step)
            report_mismatch($sformatf("current_step got %0d expected %0d",
                                      rsp_if.current_step, want.current_step));
        if (rsp_if.is_running !== want.is_running)
            report_mismatch($sformatf("is_running got %0b expected %0b",
                                      rsp_if.is_running, want.is_running));
    endtask

    // Watch both channels: predict on each request, check each result.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_if.valid && req_if.ready)
                advance_model(req_if.cmd, req_if.num_samples);
            if (rsp_if.valid && rsp_if.ready)
                check_step();
        end
    end

    // Watchdog on cycles with no handshake and no register write.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || cfg_we)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[%0t] timeout: no handshake for %0d cycles", $realtime, IDLE_LIMIT);
                $display("FAIL swing_step_clock_unit");
                $finish;
            end
        end
    end

    // Result sink: a random stall before each result unless stalls are off, or a long hold when asked.
    initial
    begin : rsp_sink
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rsp_hold > 0)
            begin
                stall    = rsp_hold;
                rsp_hold = 0;
            end
            else
            begin
                stall = rsp_no_stalls ? 0 : $urandom_range(0, 6);
            end
            if (stall > 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge clk); while (!rsp_if.valid);
        end
    end

    // Offer one request after a random gap unless gaps are off, and wait until it is taken.
    task automatic send_request(logic [CMD_W-1:0] cmd, logic [SAMPLES_W-1:0] samples);
        int gap;
        gap = req_no_gaps ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.cmd         <= cmd;
        req_if.num_samples <= samples;
        do @(posedge clk); while (!req_if.ready);
    endtask

    // Stop offering, wait for every expected step, then let the block go quiet.
    task automatic settle();
        req_if.valid <= 1'b0;
        while (expected_steps.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all three registers and one unused index while the block is idle.
    task automatic configure(logic [CFG_W-1:0] bpm_raw, logic [CFG_W-1:0] swing_raw,
                             logic [CFG_W-1:0] rate_raw);
        logic [BPM_W-1:0]   bpm_v;
        logic [SWING_W-1:0] swing_v;
        settle();
        bpm_v   = bpm_raw[BPM_W-1:0];
        swing_v = swing_raw[SWING_W-1:0];
        if (bpm_v < BPM_MIN)
            bpm_v = BPM_MIN;
        if (bpm_v > BPM_MAX)
            bpm_v = BPM_MAX;
        if (swing_v > SWING_MAX)
            swing_v = SWING_MAX;
        tempo_centi = bpm_v;
        swing_units = swing_v;
        rate_hz     = rate_raw;
        cfg_we    <= 1'b1;
        cfg_index <= REG_BPM;
        cfg_data  <= bpm_raw;
        @(posedge clk);
        cfg_index <= REG_SWING;
        cfg_data  <= swing_raw;
        @(posedge clk);
        cfg_index <= REG_SR;
        cfg_data  <= rate_raw;
        @(posedge clk);
        cfg_index <= REG_NONE;
        cfg_data  <= CFG_W'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Sample counts: audio-sized blocks and random values in equal share, with zero and full scale mixed in.
    function automatic logic [SAMPLES_W-1:0] random_samples();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        if (pick <= 5)
            return SAMPLES_W'($urandom_range(1, 2048));
        return SAMPLES_W'($urandom);
    endfunction

    // Directed requests: field extremes, every command and the corner cases.
    task automatic test_directed();
        // Defaults after reset: advance while stopped, unused code, then run.
        send_request(CMD_ADVANCE, 16'd1000);
        send_request(CMD_UNUSED, 16'hFFFF);
        send_request(CMD_START, 16'd0);
        send_request(CMD_ADVANCE, 16'd0);
        // A quarter beat lands exactly on the end of the first step.
        send_request(CMD_ADVANCE, 16'd6000);
        send_request(CMD_ADVANCE, 16'd1);
        send_request(CMD_START, 16'hFFFF);
        send_request(CMD_ADVANCE, 16'hFFFF);
        send_request(CMD_ADVANCE, 16'hFFFF);
        send_request(CMD_STOP, 16'h5A5A);
        send_request(CMD_ADVANCE, 16'd500);

        // Tempo below range, swing above range, zero sample rate.
        configure(18'd0, 18'd255, 18'd0);
        send_request(CMD_START, 16'd0);
        send_request(CMD_ADVANCE, 16'hFFFF);
        send_request(CMD_UNUSED, 16'd0);

        // Tempo with high data bits set, slowest sample rate: huge increments wrap.
        configure(18'h3FFFF, 18'd192, 18'd1);
        send_request(CMD_ADVANCE, 16'd1);
        send_request(CMD_ADVANCE, 16'hFFFF);
        send_request(CMD_ADVANCE, 16'd3);

        // Fastest tempo, full swing, sample rate past the nominal top.
        configure(18'd24000, 18'd192, 18'h3FFFF);
        send_request(CMD_ADVANCE, 16'hFFFF);
        send_request(CMD_ADVANCE, 16'd12345);
        send_request(CMD_STOP, 16'd0);
        send_request(CMD_START, 16'd0);
        send_request(CMD_ADVANCE, 16'd40000);
    endtask

    // Random phases: each with its own settings, mostly runs of advances.
    task automatic test_random_sequences(int phases, int per_phase);
        logic [CFG_W-1:0] common_rates[4];
        int sent;
        int run_len;
        common_rates = '{18'd44100, 18'd48000, 18'd96000, 18'd192000};
        for (int ph = 0; ph < phases; ph++)
        begin
            case (ph % 4)
                0: configure(CFG_W'(BPM_MIN), 18'd0, 18'd48000);
                1: configure(CFG_W'(BPM_MAX), CFG_W'(SWING_MAX), 18'd192000);
                default:
                begin
                    configure(CFG_W'($urandom), CFG_W'($urandom_range(0, 255)),
                              ($urandom_range(0, 3) == 0) ? CFG_W'($urandom)
                                  : common_rates[$urandom_range(0, 3)]);
                end
            endcase
            req_no_gaps   = ($urandom_range(0, 3) == 0);
            rsp_no_stalls = ($urandom_range(0, 3) == 0);
            sent = 0;
            while (sent < per_phase)
            begin
                // Usually start, then a run of advances with a little noise.
                if ($urandom_range(0, 9) != 0)
                begin
                    send_request(CMD_START, SAMPLES_W'($urandom));
                    sent++;
                end
                run_len = $urandom_range(4, 30);
                for (int i = 0; i < run_len; i++)
                begin
                    case ($urandom_range(0, 19))
                        0: send_request(CMD_UNUSED, SAMPLES_W'($urandom));
                        1: send_request(CMD_START, SAMPLES_W'($urandom));
                        default: send_request(CMD_ADVANCE, random_samples());
                    endcase
                    sent++;
                end
                if ($urandom_range(0, 1) == 0)
                begin
                    send_request(CMD_STOP, SAMPLES_W'($urandom));
                    sent++;
                end
            end
        end
        req_no_gaps   = 1'b0;
        rsp_no_stalls = 1'b0;
    endtask

    // The sink holds off for a long stretch while requests keep coming,
    // then the sender pauses until every result has come back.
    task automatic test_backpressure();
        configure(18'd12000, 18'd96, 18'd48000);
        req_no_gaps = 1'b1;
        for (int round = 0; round < 2; round++)
        begin
            rsp_hold = LONG_HOLD;
            send_request(CMD_START, 16'd0);
            for (int i = 0; i < 12; i++)
                send_request(CMD_ADVANCE, random_samples());
            settle();
        end
        req_no_gaps = 1'b0;
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.cmd         <= CMD_ADVANCE;
        req_if.num_samples <= '0;
        rsp_if.ready       <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= REG_BPM;
        cfg_data           <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_sequences(6, 130);
        test_backpressure();
        settle();

        if (mismatches == 0)
            $display("PASS swing_step_clock_unit");
        else
            $display("FAIL swing_step_clock_unit");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/swsc_pkg.sv
rtl/swsc_if.sv
rtl/swsc_datapath.sv
rtl/swsc_controller.sv
rtl/swing_step_clock_unit.sv
tb/swing_step_clock_unit_tb.sv
